// ===== hw/rtl/dta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descriptor table allocator package
// Operation and status codes, default sizes and search constants.
// ----------------------------------------------------------------------------
package dta_pkg;

    localparam int BANKS_DEF = 4;
    localparam int SLOTS_DEF = 64;
    localparam int SHIFT_DEF = 16;

    // free-slot search works on groups of this many slots
    localparam int GRP_BITS = 8;
    localparam int GRP_LOW_W = 3;

    localparam int OP_W = 2;
    localparam int ST_W = 2;
    localparam int DESC_W = 32;
    localparam int NDESC_W = 19;
    localparam int HANDLE_W = 32;
    localparam int CPU_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_CLOSE  = 2'd1,
        OP_LOOKUP = 2'd2,
        OP_RSVD   = 2'd3
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK   = 2'd0,
        ST_BAD  = 2'd1,
        ST_FULL = 2'd2,
        ST_RSVD = 2'd3
    } t_status;

endpackage

// ===== hw/rtl/dta_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module dta_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/descriptor_table_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descriptor table allocator
// Per-CPU descriptor table: lowest-free allocate, close and lookup.
// ----------------------------------------------------------------------------
//  channel   signals                       transfer when
//  in        i_in_valid / o_in_ready       i_in_valid & o_in_ready
//  out       o_out_valid / i_out_ready     o_out_valid & i_out_ready
//
//  Every operation runs an accept step (bank row search or RAM read),
//  then a finish step (slot pick, table update, result register load).
//  Handles and close-on-exec bits live in one RAM; valid bits in flops.
//  Reset clears all valid bits at once, no clearing pass.
//  The finish cycle waits while the result register is still full.
// ----------------------------------------------------------------------------
module descriptor_table_allocator
    import dta_pkg::*;
#(
    parameter int BANKS = BANKS_DEF,
    parameter int SLOTS = SLOTS_DEF,
    parameter int SHIFT = SHIFT_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [OP_W-1:0]            i_operation,
    input  logic signed [DESC_W-1:0]   i_descriptor,
    input  logic [HANDLE_W-1:0]        i_file_handle,
    input  logic                       i_per_cpu,
    input  logic [CPU_W-1:0]           i_current_cpu,
    input  logic                       i_close_on_exec,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [ST_W-1:0]            o_status,
    output logic signed [NDESC_W-1:0]  o_new_descriptor,
    output logic [HANDLE_W-1:0]        o_found_handle,
    output logic                       o_slot_in_use
);

    localparam int ENTRIES = BANKS * SLOTS;
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int NGRP = (SLOTS + GRP_BITS - 1) / GRP_BITS;
    localparam int GSEL_W = (NGRP > 1) ? $clog2(NGRP) : 1;
    localparam int RAM_W = HANDLE_W + 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_FIN  = 2'b10
    } t_state;

    t_state r_state, n_state;

    logic [ENTRIES-1:0] r_valid;

    t_op                   r_op;
    logic                  r_ok;
    logic [IDX_W-1:0]      r_idx;
    logic [HANDLE_W-1:0]   r_handle;
    logic                  r_coe;
    logic [CPU_W-1:0]      r_abank;
    logic [NGRP-1:0]       r_grp_free;
    logic [GRP_LOW_W-1:0]  r_grp_low [NGRP];

    logic                  r_out_valid;
    logic [ST_W-1:0]       r_status;
    logic [NDESC_W-1:0]    r_new_desc;
    logic [HANDLE_W-1:0]   r_found;
    logic                  r_in_use;

    // accept-side decode
    logic                  w_accept;
    logic [DESC_W-1:0]     w_d;
    logic [DESC_W-1:0]     w_dec_bank;
    logic [DESC_W-1:0]     w_dec_slot;
    logic                  w_dec_ok;
    logic [IDX_W-1:0]      w_dec_idx;
    logic [CPU_W-1:0]      w_abank;
    logic                  w_abank_ok;
    logic [IDX_W-1:0]      w_row_base;
    logic [SLOTS-1:0]      w_row;
    logic [NGRP*GRP_BITS-1:0] w_row_pad;
    logic [NGRP-1:0]       w_grp_free;
    logic [GRP_LOW_W-1:0]  w_grp_low [NGRP];

    // finish-side
    logic                  w_fin_go;
    logic [GSEL_W-1:0]     w_sel_grp;
    logic                  w_hit;
    logic [31:0]           w_slot32;
    logic [IDX_W-1:0]      w_alloc_idx;
    logic [31:0]           w_desc32;
    logic [RAM_W-1:0]      w_rdata;
    logic                  w_we;
    logic [IDX_W-1:0]      w_waddr;
    logic [RAM_W-1:0]      w_wdata;
    logic [ST_W-1:0]       w_status;
    logic [NDESC_W-1:0]    w_new_desc;
    logic [HANDLE_W-1:0]   w_found;
    logic                  w_in_use;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept = i_in_valid && o_in_ready;
    assign w_fin_go = (r_state == S_FIN) && (!r_out_valid || i_out_ready);

    // descriptor decode
    assign w_d = DESC_W'(i_descriptor);
    assign w_dec_bank = {1'b0, w_d[DESC_W-2:0]} >> SHIFT;
    assign w_dec_slot = w_d & ((32'd1 << SHIFT) - 32'd1);
    assign w_dec_ok = !w_d[DESC_W-1] && (w_dec_bank < 32'(BANKS))
                      && (w_dec_slot < 32'(SLOTS));
    assign w_dec_idx = IDX_W'(w_dec_bank * 32'(SLOTS) + w_dec_slot);

    // allocation bank row, split into groups
    assign w_abank = i_per_cpu ? i_current_cpu : '0;
    assign w_abank_ok = (32'(w_abank) < 32'(BANKS));
    assign w_row_base = w_abank_ok ? IDX_W'(32'(w_abank) * 32'(SLOTS)) : '0;
    assign w_row = r_valid[w_row_base +: SLOTS];

    always_comb begin
        w_row_pad = '1;
        w_row_pad[SLOTS-1:0] = w_row;
        for (int g = 0; g < NGRP; g++) begin
            w_grp_free[g] = w_abank_ok && !(&w_row_pad[g*GRP_BITS +: GRP_BITS]);
            w_grp_low[g] = '0;
            for (int b = GRP_BITS - 1; b >= 0; b--) begin
                if (!w_row_pad[g*GRP_BITS + b]) begin
                    w_grp_low[g] = GRP_LOW_W'(b);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op <= t_op'(i_operation);
            r_ok <= w_dec_ok;
            r_idx <= w_dec_idx;
            r_handle <= i_file_handle;
            r_coe <= i_close_on_exec;
            r_abank <= w_abank;
            r_grp_free <= w_grp_free;
            r_grp_low <= w_grp_low;
        end
    end

    // lowest free group, then its slot
    always_comb begin
        w_sel_grp = '0;
        for (int g = NGRP - 1; g >= 0; g--) begin
            if (r_grp_free[g]) begin
                w_sel_grp = GSEL_W'(g);
            end
        end
    end

    assign w_hit = |r_grp_free;
    assign w_slot32 = 32'(w_sel_grp) * 32'(GRP_BITS) + 32'(r_grp_low[w_sel_grp]);
    assign w_alloc_idx = IDX_W'(32'(r_abank) * 32'(SLOTS) + w_slot32);
    assign w_desc32 = (32'(r_abank) << SHIFT) | 32'(SLOT_W'(w_slot32));

    dta_ram #(
        .WIDTH (RAM_W),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_accept && (t_op'(i_operation) == OP_LOOKUP)),
        .i_raddr (w_dec_idx),
        .o_rdata (w_rdata)
    );

    always_comb begin
        w_we = 1'b0;
        w_waddr = w_alloc_idx;
        w_wdata = {r_coe, r_handle};
        w_status = ST_BAD;
        w_new_desc = '0;
        w_found = '0;
        w_in_use = 1'b0;
        unique case (r_op)
            OP_ALLOC: begin
                w_we = w_fin_go && w_hit;
                w_status = w_hit ? ST_OK : ST_FULL;
                w_new_desc = w_hit ? w_desc32[NDESC_W-1:0] : '1;
            end
            OP_CLOSE: begin
                w_we = w_fin_go && r_ok;
                w_waddr = r_idx;
                w_wdata = {1'b1, {HANDLE_W{1'b0}}};
                w_status = r_ok ? ST_OK : ST_BAD;
            end
            OP_LOOKUP: begin
                w_status = r_ok ? ST_OK : ST_BAD;
                w_in_use = r_ok && r_valid[r_idx];
                w_found = w_in_use ? w_rdata[HANDLE_W-1:0] : '0;
            end
            default: begin
                w_status = ST_BAD;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_fin_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_fin_go && (r_op == OP_ALLOC) && w_hit) begin
                r_valid[w_alloc_idx] <= 1'b1;
            end else if (w_fin_go && (r_op == OP_CLOSE) && r_ok) begin
                r_valid[r_idx] <= 1'b0;
            end
            if (w_fin_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fin_go) begin
            r_status <= w_status;
            r_new_desc <= w_new_desc;
            r_found <= w_found;
            r_in_use <= w_in_use;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status = r_status;
    assign o_new_descriptor = signed'(r_new_desc);
    assign o_found_handle = r_found;
    assign o_slot_in_use = r_in_use;

`ifndef SYNTHESIS
    a_accept_to_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_FIN))
        else $error("accepted transfer did not move to finish");

    a_alloc_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin_go && (r_op == OP_ALLOC) && w_hit) |=> r_valid[$past(w_alloc_idx)])
        else $error("allocated slot not marked valid");

    a_close_clears_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin_go && (r_op == OP_CLOSE) && r_ok) |=> !r_valid[$past(r_idx)])
        else $error("closed slot still valid");

    a_full_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL)) |-> (&o_new_descriptor))
        else $error("full status without all-ones descriptor");
`endif

endmodule

// ===== bench/tb_descriptor_table_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Descriptor table allocator testbench
// Drives allocate, close, lookup and reserved-code transfers with random gaps on both sides,
// predicts every result from a private copy of the table and compares each
// output transfer field by field, in order.
// ----------------------------------------------------------------------------
module tb_descriptor_table_allocator;
    import dta_pkg::*;

    localparam int NBANK = BANKS_DEF;
    localparam int NSLOT = SLOTS_DEF;
    localparam int SH = SHIFT_DEF;
    localparam int NENT = NBANK * NSLOT;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_AT = 600;
    localparam int HOLD_AT = 400;
    localparam int HOLD_LEN = 300;

    typedef struct {
        t_op                 op;
        logic [DESC_W-1:0]   desc;
        logic [HANDLE_W-1:0] handle;
        logic                per_cpu;
        logic [CPU_W-1:0]    cpu;
        logic                coe;
    } t_table_op;

    typedef struct {
        t_status                    status;
        logic signed [NDESC_W-1:0]  new_desc;
        logic [HANDLE_W-1:0]        handle;
        logic                       in_use;
    } t_table_res;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic [OP_W-1:0]            i_operation = '0;
    logic signed [DESC_W-1:0]   i_descriptor = '0;
    logic [HANDLE_W-1:0]        i_file_handle = '0;
    logic                       i_per_cpu = 1'b0;
    logic [CPU_W-1:0]           i_current_cpu = '0;
    logic                       i_close_on_exec = 1'b0;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;
    logic [ST_W-1:0]            o_status;
    logic signed [NDESC_W-1:0]  o_new_descriptor;
    logic [HANDLE_W-1:0]        o_found_handle;
    logic                       o_slot_in_use;

    descriptor_table_allocator #(
        .BANKS(NBANK),
        .SLOTS(NSLOT),
        .SHIFT(SH)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_operation(i_operation),
        .i_descriptor(i_descriptor),
        .i_file_handle(i_file_handle),
        .i_per_cpu(i_per_cpu),
        .i_current_cpu(i_current_cpu),
        .i_close_on_exec(i_close_on_exec),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_status(o_status),
        .o_new_descriptor(o_new_descriptor),
        .o_found_handle(o_found_handle),
        .o_slot_in_use(o_slot_in_use)
    );

    always #6 i_clk = ~i_clk;

    t_table_op  op_queue[$];
    t_table_res pending_results[$];

    // predicted table contents
    logic                tbl_valid[NENT];
    logic [HANDLE_W-1:0] tbl_handle[NENT];
    logic                tbl_coe[NENT];

    // stimulus-side view: which slots are live, and written prefix per bank
    logic gen_live[NENT];
    int   gen_hw[NBANK];

    int n_sent = 0;
    int n_checked = 0;
    int n_bad = 0;
    int cycles = 0;

    function automatic bit desc_index(input logic [DESC_W-1:0] d, output int idx);
        logic [DESC_W-1:0] bank, slot;
        bank = d >> SH;
        slot = d & ((32'd1 << SH) - 32'd1);
        idx = 0;
        if (d[DESC_W-1] || bank >= NBANK || slot >= NSLOT)
            return 1'b0;
        idx = int'(bank) * NSLOT + int'(slot);
        return 1'b1;
    endfunction

    function automatic t_table_res table_outcome(input t_table_op it);
        t_table_res r;
        int bank, idx;
        r.status = ST_BAD;
        r.new_desc = '0;
        r.handle = '0;
        r.in_use = 1'b0;
        case (it.op)
            OP_ALLOC: begin
                bank = it.per_cpu ? int'(it.cpu) : 0;
                r.status = ST_FULL;
                r.new_desc = -19'sd1;
                if (bank < NBANK) begin
                    for (int s = 0; s < NSLOT; s++) begin
                        idx = bank * NSLOT + s;
                        if (!tbl_valid[idx]) begin
                            tbl_valid[idx] = 1'b1;
                            tbl_handle[idx] = it.handle;
                            tbl_coe[idx] = it.coe;
                            r.status = ST_OK;
                            r.new_desc = NDESC_W'((bank << SH) | s);
                            break;
                        end
                    end
                end
            end
            OP_CLOSE: begin
                if (desc_index(it.desc, idx)) begin
                    tbl_valid[idx] = 1'b0;
                    tbl_coe[idx] = 1'b1;
                    r.status = ST_OK;
                end
            end
            OP_LOOKUP: begin
                if (desc_index(it.desc, idx)) begin
                    r.status = ST_OK;
                    if (tbl_valid[idx]) begin
                        r.in_use = 1'b1;
                        r.handle = tbl_handle[idx];
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic t_table_op mk_op(input t_op op, input logic [DESC_W-1:0] d,
                                        input logic [HANDLE_W-1:0] h, input logic pc,
                                        input logic [CPU_W-1:0] cpu, input logic coe);
        t_table_op it;
        it.op = op;
        it.desc = d;
        it.handle = h;
        it.per_cpu = pc;
        it.cpu = cpu;
        it.coe = coe;
        return it;
    endfunction

    function automatic logic [DESC_W-1:0] mk_desc(input int bank, input int slot);
        return (DESC_W'(bank) << SH) | DESC_W'(slot);
    endfunction

    task automatic gen_push(input t_table_op it);
        int b, idx;
        op_queue.push_back(it);
        if (it.op == OP_ALLOC) begin
            b = it.per_cpu ? int'(it.cpu) : 0;
            for (int s = 0; s < NSLOT; s++) begin
                if (!gen_live[b * NSLOT + s]) begin
                    gen_live[b * NSLOT + s] = 1'b1;
                    if (s + 1 > gen_hw[b])
                        gen_hw[b] = s + 1;
                    break;
                end
            end
        end else if (it.op == OP_CLOSE && desc_index(it.desc, idx)) begin
            gen_live[idx] = 1'b0;
        end
    endtask

    function automatic logic [DESC_W-1:0] noise_desc();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return {1'b1, 31'($urandom)};
            2: return mk_desc($urandom_range(NBANK, 32767), $urandom_range(0, NSLOT - 1));
            default: return mk_desc($urandom_range(0, NBANK - 1),
                                    $urandom_range(NSLOT, 65535));
        endcase
    endfunction

    // alloc_pct sets how hard the segment fills its favored bank
    task automatic gen_segment(input int n, input int alloc_pct, input int fav);
        int r, b;
        t_op op;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            b = $urandom_range(0, NBANK - 1);
            if (r >= alloc_pct && $urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 2))
                    0: op = OP_CLOSE;
                    1: op = OP_LOOKUP;
                    default: op = OP_RSVD;
                endcase
                gen_push(mk_op(op, noise_desc(), $urandom, 1'($urandom_range(0, 1)),
                               CPU_W'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
            end else if (r < alloc_pct || gen_hw[b] == 0) begin
                if ($urandom_range(0, 9) < 7)
                    gen_push(mk_op(OP_ALLOC, $urandom, $urandom, 1'b1, CPU_W'(fav),
                                   1'($urandom_range(0, 1))));
                else
                    gen_push(mk_op(OP_ALLOC, $urandom, $urandom, 1'($urandom_range(0, 1)),
                                   CPU_W'($urandom_range(0, 3)),
                                   1'($urandom_range(0, 1))));
            end else begin
                op = $urandom_range(0, 1) ? OP_CLOSE : OP_LOOKUP;
                gen_push(mk_op(op, mk_desc(b, $urandom_range(0, gen_hw[b] - 1)), $urandom,
                               1'($urandom_range(0, 1)), CPU_W'($urandom_range(0, 3)),
                               1'($urandom_range(0, 1))));
            end
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // driver
    int        tx_gap = 0;
    bit        tx_burst = 0;
    bit        drained = 0;
    t_table_op tx_cur;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                pending_results.push_back(table_outcome(tx_cur));
                n_sent++;
                if ($urandom_range(0, 99) == 0)
                    tx_burst = ~tx_burst;
                tx_gap = tx_burst ? 0 : pick_gap();
            end
            if ((i_in_valid && o_in_ready) || !i_in_valid) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_in_valid <= 1'b0;
                end else if (n_sent == DRAIN_AT && !drained && pending_results.size() != 0) begin
                    i_in_valid <= 1'b0;
                end else if (op_queue.size() != 0) begin
                    if (n_sent == DRAIN_AT)
                        drained = 1;
                    tx_cur = op_queue.pop_front();
                    i_operation <= tx_cur.op;
                    i_descriptor <= tx_cur.desc;
                    i_file_handle <= tx_cur.handle;
                    i_per_cpu <= tx_cur.per_cpu;
                    i_current_cpu <= tx_cur.cpu;
                    i_close_on_exec <= tx_cur.coe;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int         rx_stall = 0;
    int         rx_hold = 0;
    bit         rx_held = 0;
    bit         rx_burst = 0;
    t_table_res rx_want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                n_checked++;
                if (pending_results.size() == 0) begin
                    if (n_bad < 10)
                        $display("unexpected result: status %0d new_desc %0d handle %h use %b",
                                 o_status, o_new_descriptor, o_found_handle, o_slot_in_use);
                    n_bad++;
                end else begin
                    rx_want = pending_results.pop_front();
                    if (o_status !== rx_want.status || o_new_descriptor !== rx_want.new_desc ||
                        o_found_handle !== rx_want.handle || o_slot_in_use !== rx_want.in_use)
                    begin
                        if (n_bad < 10) begin
                            $display("mismatch at result %0d:", n_checked);
                            $display("  exp status %0d new_desc %0d handle %h use %b",
                                     rx_want.status, rx_want.new_desc, rx_want.handle,
                                     rx_want.in_use);
                            $display("  got status %0d new_desc %0d handle %h use %b",
                                     o_status, o_new_descriptor, o_found_handle,
                                     o_slot_in_use);
                        end
                        n_bad++;
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_out_ready <= 1'b0;
            end else if (!rx_held && n_checked >= HOLD_AT) begin
                rx_held = 1;
                rx_hold = HOLD_LEN;
                i_out_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 99) == 0)
                    rx_burst = ~rx_burst;
                if (!rx_burst && $urandom_range(0, 99) >= 70)
                    rx_stall = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NENT; i++) begin
            tbl_valid[i] = 1'b0;
            tbl_handle[i] = '0;
            tbl_coe[i] = 1'b1;
            gen_live[i] = 1'b0;
        end
        for (int b = 0; b < NBANK; b++)
            gen_hw[b] = 0;

        // directed: extremes, reuse of lowest slot, free-slot cases, bad descriptors
        gen_push(mk_op(OP_ALLOC, 32'h0, 32'h0, 1'b0, 2'd3, 1'b0));
        gen_push(mk_op(OP_ALLOC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 2'd3, 1'b1));
        gen_push(mk_op(OP_ALLOC, 32'h0, 32'hA5A5_A5A5, 1'b1, 2'd1, 1'b0));
        gen_push(mk_op(OP_ALLOC, 32'h0, 32'h5A5A_5A5A, 1'b1, 2'd2, 1'b1));
        gen_push(mk_op(OP_ALLOC, 32'h0, 32'h1234_5678, 1'b0, 2'd2, 1'b1));
        gen_push(mk_op(OP_LOOKUP, mk_desc(0, 0), 32'hFFFF_FFFF, 1'b1, 2'd3, 1'b1));
        gen_push(mk_op(OP_LOOKUP, mk_desc(3, 0), 32'h0, 1'b0, 2'd0, 1'b0));
        gen_push(mk_op(OP_CLOSE, mk_desc(0, 0), 32'h0, 1'b0, 2'd0, 1'b0));
        gen_push(mk_op(OP_LOOKUP, mk_desc(0, 0), 32'h0, 1'b0, 2'd0, 1'b0));
        gen_push(mk_op(OP_CLOSE, mk_desc(0, 0), 32'h0, 1'b0, 2'd0, 1'b0));
        gen_push(mk_op(OP_ALLOC, 32'h0, 32'hDEAD_BEEF, 1'b0, 2'd1, 1'b1));
        gen_push(mk_op(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 1'b0, 2'd0, 1'b0));
        gen_push(mk_op(OP_CLOSE, 32'h8000_0000, 32'h0, 1'b0, 2'd0, 1'b0));
        gen_push(mk_op(OP_LOOKUP, mk_desc(0, NSLOT), 32'h0, 1'b0, 2'd0, 1'b0));
        gen_push(mk_op(OP_CLOSE, mk_desc(NBANK, 0), 32'h0, 1'b0, 2'd0, 1'b0));
        gen_push(mk_op(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0, 1'b0, 2'd0, 1'b0));
        gen_push(mk_op(OP_LOOKUP, 32'h0000_FFFF, 32'h0, 1'b0, 2'd0, 1'b0));
        gen_push(mk_op(OP_RSVD, 32'h0, 32'h0, 1'b0, 2'd0, 1'b0));
        gen_push(mk_op(OP_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 2'd3, 1'b1));
        gen_push(mk_op(OP_CLOSE, mk_desc(3, 0), 32'h0, 1'b0, 2'd0, 1'b0));
        gen_push(mk_op(OP_LOOKUP, mk_desc(3, 0), 32'h0, 1'b0, 2'd0, 1'b0));
        gen_push(mk_op(OP_LOOKUP, mk_desc(1, 0), 32'h0, 1'b0, 2'd0, 1'b0));

        // random segments; heavy-allocation ones run banks full
        gen_segment(150, 85, $urandom_range(0, NBANK - 1));
        gen_segment(150, 30, $urandom_range(0, NBANK - 1));
        gen_segment(150, 60, $urandom_range(0, NBANK - 1));
        gen_segment(150, 85, 0);
        for (int k = 0; k < 3; k++) begin
            case ($urandom_range(0, 2))
                0: gen_segment(150, 85, $urandom_range(0, NBANK - 1));
                1: gen_segment(150, 60, $urandom_range(0, NBANK - 1));
                default: gen_segment(150, 30, $urandom_range(0, NBANK - 1));
            endcase
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (op_queue.size() != 0 || i_in_valid || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (n_bad == 0 && pending_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/dta_pkg.sv
hw/rtl/dta_ram.sv
hw/rtl/descriptor_table_allocator.sv
bench/tb_descriptor_table_allocator.sv
